@@ rtl/prl_pkg.sv @@
// shared types and constants of the rms mouth level meter
`default_nettype none
package prl_pkg;

    // item and register widths
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 13;
    localparam int SKIP_W     = 10;
    localparam int WLEN_W     = 11;
    localparam int GAIN_W     = 8;
    localparam int SQ_BITS    = 31;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // defaults and fixed scaling
    localparam int WINDOW_MAX_DEF = 1024;
    localparam int GAIN_SHIFT     = 3;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 13'd4096;
    localparam logic [SKIP_W-1:0]  SKIP_RESET   = 10'd22;
    localparam logic [WLEN_W-1:0]  WLEN_RESET   = 11'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 8'd8;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SKIP = 2'd0;
    localparam logic [1:0] REG_WLEN = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;

    typedef struct packed {
        logic [SKIP_W-1:0] skip_samples;
        logic [WLEN_W-1:0] window_len;
        logic [GAIN_W-1:0] level_gain;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/prl_regs.sv @@
// configuration registers behind the apb-style port
`default_nettype none
module prl_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [prl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [prl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [prl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output prl_pkg::cfg_t                        cfg
);
    import prl_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] index;
    logic       wr_en;

    assign index  = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_samples <= SKIP_RESET;
            cfg_reg.window_len   <= WLEN_RESET;
            cfg_reg.level_gain   <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_SKIP: cfg_reg.skip_samples <= pwdata[SKIP_W-1:0];
                REG_WLEN: cfg_reg.window_len   <= pwdata[WLEN_W-1:0];
                REG_GAIN: cfg_reg.level_gain   <= pwdata[GAIN_W-1:0];
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (index)
            REG_SKIP: prdata = CFG_DATA_W'(cfg_reg.skip_samples);
            REG_WLEN: prdata = CFG_DATA_W'(cfg_reg.window_len);
            REG_GAIN: prdata = CFG_DATA_W'(cfg_reg.level_gain);
            default:  prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/prl_csu.sv @@
// shared compare and subtract unit for the divide and square root steps
`default_nettype none
module prl_csu #(
    parameter int W = 24
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic [W-1:0]      diff
);
    logic [W:0] wide;

    // one borrow chain gives both the compare and the difference
    always_comb
    begin
        wide = {1'b0, a} - {1'b0, b};
        ge   = !wide[W];
        diff = wide[W-1:0];
    end

endmodule
`default_nettype wire

@@ rtl/prl_level.sv @@
// level engine: restoring divide, digit-by-digit square root, gain and clamp
`default_nettype none
module prl_level #(
    parameter int WINDOW_MAX = prl_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     start,
    input  wire logic [prl_pkg::SQ_BITS-2+$clog2(WINDOW_MAX+1):0] sum,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]          count,
    input  wire logic [prl_pkg::GAIN_W-1:0]               gain,
    output logic                                          done,
    output logic      [prl_pkg::LEVEL_W-1:0]              level
);
    import prl_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SQ_BITS - 1 + CNT_W;
    localparam int SQ_W   = SUM_W + (SUM_W % 2);
    localparam int RT_W   = SQ_W / 2;
    localparam int U_W    = (CNT_W + 1 > RT_W + 3) ? CNT_W + 1 : RT_W + 3;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int PROD_W = RT_W + GAIN_W;

    typedef enum logic [2:0] {E_IDLE, E_DIV, E_SQRT, E_MUL, E_CLAMP} eng_state_t;

    eng_state_t          state_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [SQ_W-1:0]     sqv_reg;
    logic [RT_W:0]       srem_reg;
    logic [RT_W-1:0]     root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                done_reg;
    logic [LEVEL_W-1:0]  level_reg;

    logic [U_W-1:0]      ua;
    logic [U_W-1:0]      ub;
    logic                ge;
    logic [U_W-1:0]      diff;
    logic [SUM_W-1:0]    quo_next;
    logic [PROD_W-1:0]   scaled;

    prl_csu #(.W(U_W)) u_csu (
        .a    (ua),
        .b    (ub),
        .ge   (ge),
        .diff (diff)
    );

    // operand selection for the shared unit
    always_comb
    begin
        if (state_reg == E_DIV)
        begin
            ua = U_W'({rem_reg, quo_reg[SUM_W-1]});
            ub = U_W'(div_reg);
        end
        else
        begin
            ua = U_W'({srem_reg, sqv_reg[SQ_W-1 -: 2]});
            ub = U_W'({root_reg, 2'b01});
        end
        quo_next = {quo_reg[SUM_W-2:0], ge};
        scaled   = prod_reg >> GAIN_SHIFT;
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            quo_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            sqv_reg   <= '0;
            srem_reg  <= '0;
            root_reg  <= '0;
            step_reg  <= '0;
            prod_reg  <= '0;
            done_reg  <= 1'b0;
            level_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == E_CLAMP);
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        quo_reg   <= sum;
                        rem_reg   <= '0;
                        div_reg   <= count;
                        step_reg  <= STEP_W'(SUM_W - 1);
                        state_reg <= E_DIV;
                    end
                end
                // one quotient bit a cycle
                E_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= ge ? diff[CNT_W-1:0] : ua[CNT_W-1:0];
                    if (step_reg == '0)
                    begin
                        sqv_reg   <= SQ_W'(quo_next);
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(RT_W - 1);
                        state_reg <= E_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                // one root bit a cycle, two operand bits consumed
                E_SQRT:
                begin
                    sqv_reg  <= sqv_reg << 2;
                    srem_reg <= ge ? diff[RT_W:0] : ua[RT_W:0];
                    root_reg <= {root_reg[RT_W-2:0], ge};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= E_MUL;
                    end
                end
                E_MUL:
                begin
                    prod_reg  <= PROD_W'(root_reg) * PROD_W'(gain);
                    state_reg <= E_CLAMP;
                end
                E_CLAMP:
                begin
                    level_reg <= (scaled > PROD_W'(FULL_LEVEL)) ? FULL_LEVEL
                                                                : scaled[LEVEL_W-1:0];
                    state_reg <= E_IDLE;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule
`default_nettype wire

@@ rtl/pcm_rms_mouth_level.sv @@
// A dropped header item passes S_TAIL, a summed item S_SQUARE, S_ACCUM and S_TAIL, before
// ready again. An item that closes a window adds the level engine: SUM_W divide steps,
// RT_W root steps, a multiply and a clamp; divide and root share one compare-subtract unit.
// Throughput: one item at a time; results leave through a one-deep output register.
// Reset: rst_n is asynchronous, active low; sums, counts and registers return to defaults.
`default_nettype none
module pcm_rms_mouth_level #(
    parameter int WINDOW_MAX = prl_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [prl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [prl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [prl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // [15:0] pcm_sample
    input  wire logic                            s_tlast,   // clip_end
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [15:0]                     m_tdata,   // [12:0] mouth_level
    output logic                                 m_tlast    // last_of_run
);
    import prl_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SQ_BITS - 1 + CNT_W;
    localparam int EW_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SQUARE, S_ACCUM, S_TAIL, S_LEVEL, S_EMIT, S_ZERO
    } state_t;

    cfg_t                 cfg;
    state_t               state_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic                 last_reg;
    logic                 full_reg;
    logic [SQ_BITS-1:0]   sq_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SKIP_W-1:0]    header_reg;
    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [LEVEL_W-1:0]   m_level_reg;

    logic                 drop;
    logic [SAMPLE_W:0]    mag;
    logic [2*SAMPLE_W+1:0] mag_sq;
    logic [SUM_W-1:0]     sum_next;
    logic [CNT_W-1:0]     count_next;
    logic [EW_W-1:0]      eff_win;
    logic                 win_full;
    logic                 lvl_start;
    logic                 lvl_done;
    logic [LEVEL_W-1:0]   lvl_level;
    logic                 out_free;
    logic                 out_load;

    prl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prl_level #(.WINDOW_MAX(WINDOW_MAX)) u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lvl_start),
        .sum   (sum_reg),
        .count (count_reg),
        .gain  (cfg.level_gain),
        .done  (lvl_done),
        .level (lvl_level)
    );

    // magnitude, square, window bookkeeping
    always_comb
    begin
        drop = header_reg < cfg.skip_samples;
        mag  = sample_reg[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, sample_reg})
                                      : {1'b0, sample_reg};
        mag_sq     = mag * mag;
        sum_next   = sum_reg + SUM_W'(sq_reg);
        count_next = count_reg + 1'b1;
        if (cfg.window_len == '0)
            eff_win = EW_W'(1);
        else if (EW_W'(cfg.window_len) > EW_W'(WINDOW_MAX))
            eff_win = EW_W'(WINDOW_MAX);
        else
            eff_win = EW_W'(cfg.window_len);
        win_full  = EW_W'(count_next) >= eff_win;
        lvl_start = (state_reg == S_TAIL) && (full_reg || (last_reg && count_reg != '0));
        out_free  = !m_tvalid_reg || m_tready;
        out_load  = ((state_reg == S_EMIT) || (state_reg == S_ZERO)) && out_free;
    end

    // sequencer, accumulator and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sample_reg   <= '0;
            last_reg     <= 1'b0;
            full_reg     <= 1'b0;
            sq_reg       <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            header_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_level_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sample_reg <= s_tdata;
                        last_reg   <= s_tlast;
                        full_reg   <= 1'b0;
                        if (drop)
                        begin
                            header_reg <= header_reg + 1'b1;
                            state_reg  <= S_TAIL;
                        end
                        else
                        begin
                            state_reg <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE:
                begin
                    sq_reg    <= mag_sq[SQ_BITS-1:0];
                    state_reg <= S_ACCUM;
                end
                S_ACCUM:
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    full_reg  <= win_full;
                    state_reg <= S_TAIL;
                end
                // hand a closed or partial window to the engine, or finish the item
                S_TAIL:
                begin
                    if (last_reg)
                        header_reg <= '0;
                    if (lvl_start)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= S_LEVEL;
                    end
                    else if (last_reg)
                        state_reg <= S_ZERO;
                    else
                        state_reg <= S_IDLE;
                end
                S_LEVEL:
                begin
                    if (lvl_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_level_reg  <= lvl_level;
                        m_tlast_reg  <= !last_reg;
                        state_reg    <= last_reg ? S_ZERO : S_IDLE;
                    end
                end
                // closing zero level of a clip
                S_ZERO:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_level_reg  <= '0;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(m_level_reg);
    assign m_tlast  = m_tlast_reg;

    // level never above fully open
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_level_reg <= FULL_LEVEL))
        else $error("mouth level above full scale");

    // window count never passes the largest window
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        EW_W'(count_reg) <= EW_W'(WINDOW_MAX))
        else $error("window count beyond maximum");

    // a non-final level is always followed by the closing zero
    a_zero_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tlast_reg) |-> (state_reg == S_ZERO))
        else $error("partial result without closing zero pending");

endmodule
`default_nettype wire

@@ sim/prl_level_checker.sv @@
// checker of the rms mouth level meter: mirrors the level arithmetic and compares every result
module prl_level_checker #(
    parameter int WINDOW_MAX = prl_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [prl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [prl_pkg::CFG_DATA_W-1:0] pwdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [15:0]                    s_tdata,   // [15:0] pcm_sample
    input  wire logic                           s_tlast,   // clip_end
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [15:0]                    m_tdata,   // [12:0] mouth_level
    input  wire logic                           m_tlast,   // last_of_run
    output int                                  fail_count,
    output int                                  levels_owed
);
    import prl_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last;
    } level_exp_t;

    // expected levels, oldest first
    level_exp_t  level_fifo[$];

    // mirrored registers and window state
    cfg_t        cfg_mirror;
    logic [63:0] sq_acc;
    int unsigned win_cnt;
    int unsigned hdr_cnt;
    int          n_bad = 0;

    task automatic report_mismatch(input string msg);
        n_bad++;
        if (n_bad <= MAX_PRINTS)
            $display("level mismatch at %0t: %s", $time, msg);
    endtask

    // bit-by-bit integer square root, result fits 17 bits for a 31-bit mean
    function automatic logic [16:0] int_sqrt(input logic [63:0] v);
        logic [16:0] r;
        logic [16:0] trial;
        r = '0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = r | (17'd1 << b);
            if ({47'd0, trial} * {47'd0, trial} <= v)
                r = trial;
        end
        return r;
    endfunction

    // clamp of the window length to 1 .. WINDOW_MAX
    function automatic int unsigned eff_window(input logic [WLEN_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > WINDOW_MAX)
            return WINDOW_MAX;
        return w;
    endfunction

    // level of the current window: root of the mean square, gain, shift, saturation
    function automatic logic [LEVEL_W-1:0] mean_level();
        logic [63:0] cnt64;
        logic [63:0] lvl;
        if (win_cnt == 0)
            return '0;
        cnt64 = win_cnt;
        lvl = ({47'd0, int_sqrt(sq_acc / cnt64)} * {56'd0, cfg_mirror.level_gain}) >> GAIN_SHIFT;
        if (lvl > FULL_LEVEL)
            lvl = FULL_LEVEL;
        return lvl[LEVEL_W-1:0];
    endfunction

    // one sample in, up to two levels queued
    task automatic predict_levels(input logic [15:0] raw, input logic clip_end);
        logic [16:0]        mag;
        logic [LEVEL_W-1:0] lv_new [0:1];
        level_exp_t         e;
        int                 n;
        n = 0;
        if (hdr_cnt < cfg_mirror.skip_samples)
            hdr_cnt++;
        else
        begin
            mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
            sq_acc += {47'd0, mag} * {47'd0, mag};
            win_cnt++;
            if (win_cnt >= eff_window(cfg_mirror.window_len))
            begin
                lv_new[n] = mean_level();
                n++;
                sq_acc  = '0;
                win_cnt = 0;
            end
        end
        // clip end: pending partial window first, then the closing zero
        if (clip_end)
        begin
            if (win_cnt > 0 && n == 0)
            begin
                lv_new[n] = mean_level();
                n++;
            end
            lv_new[n] = '0;
            n++;
            sq_acc  = '0;
            win_cnt = 0;
            hdr_cnt = 0;
        end
        for (int k = 0; k < n; k++)
        begin
            e.level = lv_new[k];
            e.last  = (k == n - 1);
            level_fifo.push_back(e);
        end
    endtask

    // watch the three ports at each edge: results first, then registers, then items
    always @(posedge clk or negedge rst_n)
    begin : watch
        level_exp_t want;
        if (!rst_n)
        begin
            cfg_mirror.skip_samples = SKIP_RESET;
            cfg_mirror.window_len   = WLEN_RESET;
            cfg_mirror.level_gain   = GAIN_RESET;
            sq_acc  = '0;
            win_cnt = 0;
            hdr_cnt = 0;
            level_fifo.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (level_fifo.size() == 0)
                    report_mismatch($sformatf("unexpected level %0d last %0b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = level_fifo.pop_front();
                    if (m_tdata !== {{(16-LEVEL_W){1'b0}}, want.level})
                        report_mismatch($sformatf("mouth_level got %0d want %0d",
                                                  m_tdata, want.level));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_of_run got %0b want %0b",
                                                  m_tlast, want.last));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SKIP: cfg_mirror.skip_samples = pwdata[SKIP_W-1:0];
                    REG_WLEN: cfg_mirror.window_len   = pwdata[WLEN_W-1:0];
                    REG_GAIN: cfg_mirror.level_gain   = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_levels(s_tdata, s_tlast);
        end
        fail_count  <= n_bad;
        levels_owed <= level_fifo.size();
    end

endmodule

@@ sim/tb_pcm_rms_mouth_level.sv @@
// testbench top of the rms mouth level meter: stimulus, register set-up and verdict
module tb_pcm_rms_mouth_level;
    import prl_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 400;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;   // [15:0] pcm_sample
    logic                  s_tlast  = 1'b0; // clip_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [12:0] mouth_level
    logic                  m_tlast;         // last_of_run

    int                    fail_count;
    int                    levels_owed;

    // stimulus bookkeeping
    bit                    no_idle   = 1'b0;
    logic [SKIP_W-1:0]     skip_now  = SKIP_RESET;
    int unsigned           hdr_now   = 0;
    int unsigned           n_counted = 0;

    pcm_rms_mouth_level #(
        .WINDOW_MAX (WINDOW_MAX_DEF)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    prl_level_checker #(
        .WINDOW_MAX (WINDOW_MAX_DEF)
    ) level_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .levels_owed (levels_owed)
    );

    // clock
    always #10 clk = ~clk;

    // receiver stalls about a third of the time unless idling is off
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(99) >= 33);

    // hard stop
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // register write: setup cycle then access cycle
    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SKIP)
            skip_now = val[SKIP_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_config(input int sk, input int wl, input int gn);
        cfg_write(REG_SKIP, sk);
        cfg_write(REG_WLEN, wl);
        cfg_write(REG_GAIN, gn);
    endtask

    // one item on the sample stream, with random gaps ahead of it
    task automatic send_sample(input logic [15:0] smp, input logic lst);
        while (!no_idle && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        if (hdr_now < skip_now)
            hdr_now++;
        else
            n_counted++;
        if (lst)
            hdr_now = 0;
    endtask

    // stop sending until every expected level is out and the block has gone quiet
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (levels_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mix of full-range, scaled-down and extreme samples
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1:
            begin
                v = $urandom();
                v = v >> $urandom_range(1, 15);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic random_settings();
        int sk;
        int wl;
        int gn;
        case ($urandom_range(0, 3))
            0: sk = 0;
            1: sk = 1;
            2: sk = $urandom_range(2, 6);
            default: sk = $urandom_range(0, 24);
        endcase
        case ($urandom_range(0, 7))
            0: wl = 0;
            1: wl = 1;
            2, 3: wl = $urandom_range(2, 8);
            4, 5: wl = $urandom_range(9, 40);
            6: wl = $urandom_range(41, 1024);
            default: wl = $urandom_range(1025, 2047);
        endcase
        case ($urandom_range(0, 4))
            0: gn = 0;
            1: gn = 255;
            default: gn = $urandom_range(0, 255);
        endcase
        set_config(sk, wl, gn);
    endtask

    // one clip, now and then paused mid-way for a register change
    task automatic run_clip(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_sample(pick_sample(), i == len - 1);
            if (i != len - 1 && $urandom_range(0, 149) == 0)
            begin
                hold_until_drained();
                case ($urandom_range(0, 2))
                    0: cfg_write(REG_WLEN, $urandom_range(1, 16));
                    1: cfg_write(REG_SKIP, $urandom_range(0, 30));
                    default: cfg_write(REG_GAIN, $urandom_range(0, 255));
                endcase
            end
        end
    endtask

    initial
    begin
        int n_clips;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: clip end inside the header gives only the closing zero
        send_sample(16'h7FFF, 1'b1);
        hold_until_drained();

        // one-sample windows at full gain across the sample extremes
        set_config(0, 1, 255);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        hold_until_drained();

        // zero gain
        cfg_write(REG_GAIN, 0);
        send_sample(16'h7FFF, 1'b1);
        hold_until_drained();

        // skip raised mid-clip while a partial window is pending
        set_config(2, 4, 8);
        send_sample(16'h1000, 1'b0);
        send_sample(16'h2000, 1'b0);
        send_sample(16'h3000, 1'b0);
        send_sample(16'hC000, 1'b0);
        hold_until_drained();
        cfg_write(REG_SKIP, 6);
        send_sample(16'h5000, 1'b1);
        hold_until_drained();

        // window lowered below the running count
        set_config(0, 8, 8);
        repeat (5) send_sample(pick_sample(), 1'b0);
        hold_until_drained();
        cfg_write(REG_WLEN, 3);
        send_sample(16'h0123, 1'b0);
        send_sample(16'hFEDC, 1'b1);
        hold_until_drained();

        // zero window length behaves as one
        cfg_write(REG_WLEN, 0);
        send_sample(16'h4000, 1'b0);
        send_sample(16'hB000, 1'b0);
        send_sample(16'h0F0F, 1'b1);
        hold_until_drained();

        // window length beyond the maximum
        cfg_write(REG_WLEN, 2047);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8001, 1'b0);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'hFF00, 1'b1);
        hold_until_drained();

        // long header and a full window of the loudest sample, no idling
        no_idle = 1'b1;
        set_config(40, 256, 8);
        for (int i = 0; i < 300; i++)
            send_sample((i < 296) ? 16'h8000 : pick_sample(), i == 299);
        hold_until_drained();
        no_idle = 1'b0;

        // random settings and clips
        n_counted = 0;
        while (n_counted < RANDOM_ITEMS)
        begin
            random_settings();
            n_clips = $urandom_range(2, 6);
            repeat (n_clips) run_clip($urandom_range(1, 60));
            hold_until_drained();
        end

        if (fail_count == 0 && levels_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
